// ----- design/bblru_pkg.sv -----
// Shared types and constants of the block buffer LRU controller.
// No dependencies; the interfaces and the controller import this package.
`timescale 1ns / 1ps

package bblru_pkg;

    localparam int MODE_W = 2;
    localparam int TAG_W  = 16;
    localparam int AGE_W  = 16;
    localparam int ACT_W  = 2;
    localparam int SLOT_W = 6;

    localparam logic [MODE_W-1:0] MODE_ACCESS    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DIRTY     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH_ONE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FLUSH_ALL = 2'd3;

    localparam logic [ACT_W-1:0] ACT_HIT       = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FILL      = 2'd1;
    localparam logic [ACT_W-1:0] ACT_WRITEBACK = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE      = 2'd3;

    localparam logic [TAG_W-1:0] FREE_TAG = 16'hFFFF;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [AGE_W-1:0] age;
        logic             dirty;
    } entry_t;

    localparam entry_t FREE_ENTRY = '{tag: FREE_TAG, age: '0, dirty: 1'b0};

endpackage

// ----- design/bblru_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on bblru_pkg for field widths.
`timescale 1ns / 1ps

interface bblru_req_if
    import bblru_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [TAG_W-1:0]  block_number;
    logic              clear_after;

    modport source (output valid, output mode, output block_number, output clear_after,
                    input ready);
    modport sink (input valid, input mode, input block_number, input clear_after,
                  output ready);
endinterface

interface bblru_res_if
    import bblru_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  target_block;
    logic              last;

    modport source (output valid, output action, output slot, output target_block,
                    output last, input ready);
    modport sink (input valid, input action, input slot, input target_block,
                  input last, output ready);
endinterface

// ----- design/bblru_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module bblru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // hold read data between reads
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/block_buffer_lru_controller.sv -----
// Top level of the block buffer LRU controller: tag lookup, victim choice, flush sequencing.
// Depends on bblru_pkg, bblru_req_if / bblru_res_if and bblru_ram.
`timescale 1ns / 1ps

// Tag and replacement controller of a fully associative write-back block cache.
// The request channel carries one word per request (mode, block_number, clear_after);
// the result channel returns one or more words per request (action, slot,
// target_block, last): up to two for a lookup, up to SLOTS for flush all, with
// last set on the final word of each request.
// Slot tags, stamps and dirty bits live in one slot RAM with a registered read;
// a valid bit per slot makes a never-written or freed slot read as free.
// A lookup request scans the RAM one slot per cycle, and a dirty victim adds a
// writeback word before the final one; flush all reads each slot in S_FREAD and
// checks it in S_FCHK, rewriting a dirty slot as clean; S_FCHK waits while the output
// register is full and a writeback must go out. The single RAM read port sets this pace.
// A free-marker request skips the scan. One request is in work at a time; the
// next one is taken while the final result word still waits in the output register.
// Reset frees every slot and zeroes the use counter at once; no clearing pass.
// When the receiver stalls, the output register holds its word and the sequencer
// waits before producing the next one; the request side stays busy meanwhile.
module block_buffer_lru_controller
    import bblru_pkg::*;
#(
    parameter int SLOTS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    bblru_req_if.sink   request,
    bblru_res_if.source result
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_PRE    = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;
    localparam logic [2:0] S_FREAD  = 3'd5;
    localparam logic [2:0] S_FCHK   = 3'd6;
    localparam logic [2:0] S_FEND   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [TAG_W-1:0]  blk_reg, blk_next;
    logic              clr_reg, clr_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              chk_reg, chk_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic              hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic              hit_dirty_reg, hit_dirty_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [AGE_W-1:0]  min_age_reg, min_age_next;
    logic [IDX_W-1:0]  min_idx_reg, min_idx_next;
    logic [TAG_W-1:0]  min_tag_reg, min_tag_next;
    logic              min_dirty_reg, min_dirty_next;
    logic [ACT_W-1:0]  fin_act_reg, fin_act_next;
    logic [IDX_W-1:0]  fin_slot_reg, fin_slot_next;
    logic [TAG_W-1:0]  fin_tgt_reg, fin_tgt_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [TAG_W-1:0]  pend_tag_reg, pend_tag_next;
    logic [IDX_W-1:0]  f_idx_reg, f_idx_next;
    logic [AGE_W-1:0]  use_cnt_reg, use_cnt_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;

    logic              res_valid_reg, res_valid_next;
    logic [ACT_W-1:0]  res_action_reg, res_action_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic [TAG_W-1:0]  res_target_reg, res_target_next;
    logic              res_last_reg, res_last_next;

    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    entry_t            ram_wr_data;
    logic              ram_rd_en;
    logic [IDX_W-1:0]  ram_rd_addr;
    entry_t            ram_rd_data;

    logic              out_free;
    logic              emit;
    logic [ACT_W-1:0]  emit_act;
    logic [IDX_W-1:0]  emit_slot;
    logic [TAG_W-1:0]  emit_tgt;
    logic              emit_last;
    entry_t            scan_ent;
    entry_t            flush_ent;
    logic [IDX_W-1:0]  victim;
    logic [AGE_W-1:0]  new_age;
    logic              new_dirty;

    bblru_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign out_free = !res_valid_reg || result.ready;

    // a slot that is not valid reads as free
    assign scan_ent  = valid_reg[chk_idx_reg] ? ram_rd_data : FREE_ENTRY;
    assign flush_ent = valid_reg[f_idx_reg] ? ram_rd_data : FREE_ENTRY;

    assign victim  = hit_found_reg ? hit_idx_reg : (free_found_reg ? free_idx_reg : min_idx_reg);
    assign new_age = AGE_W'(use_cnt_reg + 16'd1);

    always_comb
    begin
        case (mode_reg)
            MODE_DIRTY: new_dirty = 1'b1;
            MODE_ACCESS: new_dirty = hit_found_reg && hit_dirty_reg;
            default: new_dirty = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        blk_next        = blk_reg;
        clr_next        = clr_reg;
        scan_idx_next   = scan_idx_reg;
        chk_next        = chk_reg;
        chk_idx_next    = chk_idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_dirty_next  = hit_dirty_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        min_age_next    = min_age_reg;
        min_idx_next    = min_idx_reg;
        min_tag_next    = min_tag_reg;
        min_dirty_next  = min_dirty_reg;
        fin_act_next    = fin_act_reg;
        fin_slot_next   = fin_slot_reg;
        fin_tgt_next    = fin_tgt_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        pend_tag_next   = pend_tag_reg;
        f_idx_next      = f_idx_reg;
        use_cnt_next    = use_cnt_reg;
        valid_next      = valid_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = victim;
        ram_wr_data = '{tag: blk_reg, age: new_age, dirty: new_dirty};
        ram_rd_en   = 1'b0;
        ram_rd_addr = scan_idx_reg[IDX_W-1:0];

        emit      = 1'b0;
        emit_act  = ACT_NONE;
        emit_slot = '0;
        emit_tgt  = FREE_TAG;
        emit_last = 1'b1;

        request.ready = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    mode_next       = request.mode;
                    blk_next        = request.block_number;
                    clr_next        = request.clear_after;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    pend_next       = 1'b0;
                    scan_idx_next   = '0;
                    chk_next        = 1'b0;
                    f_idx_next      = '0;
                    if (request.mode == MODE_FLUSH_ALL)
                    begin
                        state_next = S_FREAD;
                    end
                    else if (request.block_number == FREE_TAG)
                    begin
                        fin_act_next  = ACT_NONE;
                        fin_slot_next = '0;
                        fin_tgt_next  = FREE_TAG;
                        state_next    = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one read per cycle, check the word read the cycle before
                if (scan_idx_reg < SLOTS_CNT)
                begin
                    ram_rd_en     = 1'b1;
                    scan_idx_next = CNT_W'(scan_idx_reg + 1'b1);
                    chk_next      = 1'b1;
                    chk_idx_next  = scan_idx_reg[IDX_W-1:0];
                end
                else
                begin
                    chk_next = 1'b0;
                end
                if (chk_reg)
                begin
                    if (!hit_found_reg && scan_ent.tag == blk_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = chk_idx_reg;
                        hit_dirty_next = scan_ent.dirty;
                    end
                    if (!free_found_reg && scan_ent.tag == FREE_TAG)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                    // strict compare keeps ties on the lower slot
                    if (chk_idx_reg == '0 || scan_ent.age < min_age_reg)
                    begin
                        min_age_next   = scan_ent.age;
                        min_idx_next   = chk_idx_reg;
                        min_tag_next   = scan_ent.tag;
                        min_dirty_next = scan_ent.dirty;
                    end
                    if (chk_idx_reg == LAST_IDX)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_DECIDE:
            begin
                use_cnt_next = new_age;
                if (mode_reg == MODE_FLUSH_ONE && clr_reg)
                begin
                    valid_next[victim] = 1'b0;
                end
                else
                begin
                    ram_wr_en          = 1'b1;
                    valid_next[victim] = 1'b1;
                end
                if (!hit_found_reg)
                begin
                    fin_act_next = ACT_FILL;
                end
                else if (mode_reg == MODE_FLUSH_ONE)
                begin
                    fin_act_next = hit_dirty_reg ? ACT_WRITEBACK : ACT_NONE;
                end
                else
                begin
                    fin_act_next = ACT_HIT;
                end
                fin_slot_next = victim;
                fin_tgt_next  = blk_reg;
                if (!hit_found_reg && !free_found_reg && min_dirty_reg)
                begin
                    state_next = S_PRE;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_PRE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_act   = ACT_WRITEBACK;
                    emit_slot  = min_idx_reg;
                    emit_tgt   = min_tag_reg;
                    emit_last  = 1'b0;
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_act   = fin_act_reg;
                    emit_slot  = fin_slot_reg;
                    emit_tgt   = fin_tgt_reg;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_FREAD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = f_idx_reg;
                state_next  = S_FCHK;
            end

            S_FCHK:
            begin
                // a newly found dirty slot pushes out the pending writeback
                if (!(flush_ent.dirty && pend_reg && !out_free))
                begin
                    if (flush_ent.dirty)
                    begin
                        if (pend_reg)
                        begin
                            emit      = 1'b1;
                            emit_act  = ACT_WRITEBACK;
                            emit_slot = pend_idx_reg;
                            emit_tgt  = pend_tag_reg;
                            emit_last = 1'b0;
                        end
                        ram_wr_en     = 1'b1;
                        ram_wr_addr   = f_idx_reg;
                        ram_wr_data   = '{tag: flush_ent.tag, age: flush_ent.age, dirty: 1'b0};
                        pend_next     = 1'b1;
                        pend_idx_next = f_idx_reg;
                        pend_tag_next = flush_ent.tag;
                    end
                    if (f_idx_reg == LAST_IDX)
                    begin
                        state_next = S_FEND;
                    end
                    else
                    begin
                        f_idx_next = IDX_W'(f_idx_reg + 1'b1);
                        state_next = S_FREAD;
                    end
                end
            end

            S_FEND:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    if (pend_reg)
                    begin
                        emit_act  = ACT_WRITEBACK;
                        emit_slot = pend_idx_reg;
                        emit_tgt  = pend_tag_reg;
                    end
                    if (clr_reg)
                    begin
                        valid_next   = '0;
                        use_cnt_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next  = res_valid_reg;
        res_action_next = res_action_reg;
        res_slot_next   = res_slot_reg;
        res_target_next = res_target_reg;
        res_last_next   = res_last_reg;
        if (emit)
        begin
            res_valid_next  = 1'b1;
            res_action_next = emit_act;
            res_slot_next   = SLOT_W'(emit_slot);
            res_target_next = emit_tgt;
            res_last_next   = emit_last;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_ACCESS;
            blk_reg        <= '0;
            clr_reg        <= 1'b0;
            scan_idx_reg   <= '0;
            chk_reg        <= 1'b0;
            chk_idx_reg    <= '0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            hit_dirty_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            min_age_reg    <= '0;
            min_idx_reg    <= '0;
            min_tag_reg    <= '0;
            min_dirty_reg  <= 1'b0;
            fin_act_reg    <= ACT_NONE;
            fin_slot_reg   <= '0;
            fin_tgt_reg    <= '0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            pend_tag_reg   <= '0;
            f_idx_reg      <= '0;
            use_cnt_reg    <= '0;
            valid_reg      <= '0;
            res_valid_reg  <= 1'b0;
            res_action_reg <= ACT_NONE;
            res_slot_reg   <= '0;
            res_target_reg <= '0;
            res_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            blk_reg        <= blk_next;
            clr_reg        <= clr_next;
            scan_idx_reg   <= scan_idx_next;
            chk_reg        <= chk_next;
            chk_idx_reg    <= chk_idx_next;
            hit_found_reg  <= hit_found_next;
            hit_idx_reg    <= hit_idx_next;
            hit_dirty_reg  <= hit_dirty_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            min_age_reg    <= min_age_next;
            min_idx_reg    <= min_idx_next;
            min_tag_reg    <= min_tag_next;
            min_dirty_reg  <= min_dirty_next;
            fin_act_reg    <= fin_act_next;
            fin_slot_reg   <= fin_slot_next;
            fin_tgt_reg    <= fin_tgt_next;
            pend_reg       <= pend_next;
            pend_idx_reg   <= pend_idx_next;
            pend_tag_reg   <= pend_tag_next;
            f_idx_reg      <= f_idx_next;
            use_cnt_reg    <= use_cnt_next;
            valid_reg      <= valid_next;
            res_valid_reg  <= res_valid_next;
            res_action_reg <= res_action_next;
            res_slot_reg   <= res_slot_next;
            res_target_reg <= res_target_next;
            res_last_reg   <= res_last_next;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.action       = res_action_reg;
    assign result.slot         = res_slot_reg;
    assign result.target_block = res_target_reg;
    assign result.last         = res_last_reg;

    // the slot RAM is never written and read at the same entry in one cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_wr_en && ram_rd_en && ram_wr_addr == ram_rd_addr))
        else $error("slot RAM read and write collide on one entry");

    // a hit can only come from a slot that holds a tag
    a_hit_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && hit_found_reg) |-> valid_reg[hit_idx_reg])
        else $error("hit reported on a free slot");

    // flush all with clear leaves every slot free and the counter at zero
    a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FEND && out_free && clr_reg) |=> (valid_reg == '0 && use_cnt_reg == '0))
        else $error("flush all with clear left state behind");

    // a fill always ends its request
    a_fill_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.action == ACT_FILL) |-> result.last)
        else $error("fill word without last");

endmodule
